>>> hw/rtl/dbw_pkg.sv
// shared types and constants for the debug break/watch unit
`default_nettype none

package dbw_pkg;

  localparam int unsigned SlotsDefault = 10;
  localparam int unsigned SlotW        = 4;
  localparam int unsigned AddrW        = 16;
  localparam int unsigned OpcodeW      = 8;
  localparam int unsigned RunLimitW    = 31;
  localparam int unsigned CountW       = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned InDataW      = 48;
  localparam int unsigned OutDataW     = 32;

  localparam logic [OpcodeW-1:0]   HaltOpcode    = 8'h76;
  localparam logic [RunLimitW-1:0] RunLimitReset = 31'd10000;

  typedef enum logic [KindW-1:0] {
    KindSetBreak   = 3'd0,
    KindSetWatch   = 3'd1,
    KindClrBreaks  = 3'd2,
    KindClrWatches = 3'd3,
    KindRunStart   = 3'd4,
    KindContinue   = 3'd5,
    KindInstr      = 3'd6,
    KindAccess     = 3'd7
  } dbw_kind_e;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } dbw_match_t;

endpackage

`default_nettype wire

>>> hw/rtl/dbw_break_table.sv
// breakpoint slot table: first-free fill, bulk clear, priority address match
`default_nettype none

module dbw_break_table #(
  parameter int unsigned SLOTS = dbw_pkg::SlotsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       set_i,
  input  wire logic                       clear_i,
  input  wire logic [dbw_pkg::AddrW-1:0]  set_addr_i,
  input  wire logic [dbw_pkg::AddrW-1:0]  probe_addr_i,
  output logic                            full_o,
  output dbw_pkg::dbw_match_t             match_o
);

  logic [SLOTS-1:0]               valid_q, valid_d;
  logic [dbw_pkg::AddrW-1:0]      addr_q [SLOTS];
  logic [SLOTS-1:0]               free_oh;
  logic                           free_seen;

  // one-hot of the lowest empty slot
  always_comb begin
    free_seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      free_oh[i] = !valid_q[i] && !free_seen;
      if (!valid_q[i]) free_seen = 1'b1;
    end
  end

  assign full_o = &valid_q;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (set_i) begin
      valid_d = valid_q | free_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (set_i && free_oh[i]) addr_q[i] <= set_addr_i;
    end
  end

  // lowest matching slot wins
  always_comb begin
    match_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && addr_q[i] == probe_addr_i) begin
        match_o.hit  = 1'b1;
        match_o.slot = dbw_pkg::SlotW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dbw_watch_table.sv
// watch range slot table: first-free fill, bulk clear, priority range match
`default_nettype none

module dbw_watch_table #(
  parameter int unsigned SLOTS = dbw_pkg::SlotsDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       set_i,
  input  wire logic                       clear_i,
  input  wire logic [dbw_pkg::AddrW-1:0]  set_low_i,
  input  wire logic [dbw_pkg::AddrW-1:0]  set_high_i,
  input  wire logic [dbw_pkg::AddrW-1:0]  probe_addr_i,
  output logic                            full_o,
  output dbw_pkg::dbw_match_t             match_o
);

  logic [SLOTS-1:0]               valid_q, valid_d;
  logic [dbw_pkg::AddrW-1:0]      low_q  [SLOTS];
  logic [dbw_pkg::AddrW-1:0]      high_q [SLOTS];
  logic [SLOTS-1:0]               free_oh;
  logic                           free_seen;

  always_comb begin
    free_seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      free_oh[i] = !valid_q[i] && !free_seen;
      if (!valid_q[i]) free_seen = 1'b1;
    end
  end

  assign full_o = &valid_q;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = '0;
    end else if (set_i) begin
      valid_d = valid_q | free_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (set_i && free_oh[i]) begin
        low_q[i]  <= set_low_i;
        high_q[i] <= set_high_i;
      end
    end
  end

  // inclusive range; low above high never matches
  always_comb begin
    match_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && probe_addr_i >= low_q[i] && probe_addr_i <= high_q[i]) begin
        match_o.hit  = 1'b1;
        match_o.slot = dbw_pkg::SlotW'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/debug_break_watch_unit.sv
// debug break/watch unit top level: request register, trigger logic, result register
// request path: a taken request waits in the request register, and its result is registered into the result register
// throughput: one request per cycle; the request register advances when the result
//   register is empty or being taken, and all table and alarm state updates happen on that advance
// reset: asynchronous active low; clears tables, alarms, count, run limit to 10000
`default_nettype none

module debug_break_watch_unit #(
  parameter int unsigned SLOTS = dbw_pkg::SlotsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dbw_pkg::RunLimitW-1:0]   cfg_wdata_i,   // run_limit
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // address[15:0], address_high[31:16], high_given[32], opcode[40:33],
  // bad_opcode[41], zero[47:42]
  input  wire logic [dbw_pkg::InDataW-1:0]     s_axis_tdata,
  input  wire logic [dbw_pkg::KindW-1:0]       s_axis_tuser,  // kind[2:0]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status[0], go_on[1], break_hit[2], break_slot[6:3], watch_hit[7],
  // watch_slot[11:8], hit_addr[27:12], count_hit[28], halt_hit[29], zero[31:30]
  output logic [dbw_pkg::OutDataW-1:0]         m_axis_tdata
);

  localparam int unsigned AW = dbw_pkg::AddrW;
  localparam int unsigned SW = dbw_pkg::SlotW;
  localparam int unsigned CW = dbw_pkg::CountW;

  // request register
  logic                         in_valid_q;
  dbw_pkg::dbw_kind_e           kind_q;
  logic [AW-1:0]                addr_q;
  logic [AW-1:0]                addr_hi_q;
  logic                         high_given_q;
  logic [dbw_pkg::OpcodeW-1:0]  opcode_q;
  logic                         bad_op_q;

  logic out_valid_q;
  logic advance;
  logic in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      kind_q       <= dbw_pkg::dbw_kind_e'(s_axis_tuser);
      addr_q       <= s_axis_tdata[15:0];
      addr_hi_q    <= s_axis_tdata[31:16];
      high_given_q <= s_axis_tdata[32];
      opcode_q     <= s_axis_tdata[40:33];
      bad_op_q     <= s_axis_tdata[41];
    end
  end

  // configuration
  logic [dbw_pkg::RunLimitW-1:0] run_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_limit_q <= dbw_pkg::RunLimitReset;
    end else if (cfg_we_i) begin
      run_limit_q <= cfg_wdata_i;
    end
  end

  // slot tables
  logic                 brk_set, brk_clr, brk_full;
  logic                 wch_set, wch_clr, wch_full;
  dbw_pkg::dbw_match_t  brk_match, wch_match;
  logic [AW-1:0]        wch_high;

  assign wch_high = high_given_q ? addr_hi_q : addr_q;

  dbw_break_table #(
    .SLOTS(SLOTS)
  ) u_break_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_i       (brk_set),
    .clear_i     (brk_clr),
    .set_addr_i  (addr_q),
    .probe_addr_i(addr_q),
    .full_o      (brk_full),
    .match_o     (brk_match)
  );

  dbw_watch_table #(
    .SLOTS(SLOTS)
  ) u_watch_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_i       (wch_set),
    .clear_i     (wch_clr),
    .set_low_i   (addr_q),
    .set_high_i  (wch_high),
    .probe_addr_i(addr_q),
    .full_o      (wch_full),
    .match_o     (wch_match)
  );

  // alarm state
  logic          brk_flag_q, brk_flag_d;
  logic [SW-1:0] brk_slot_q, brk_slot_d;
  logic          wch_flag_q, wch_flag_d;
  logic [SW-1:0] wch_slot_q, wch_slot_d;
  logic [AW-1:0] wch_addr_q, wch_addr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          cnt_hit_q, cnt_hit_d;
  logic          halt_q, halt_d;
  logic          status_q, status_d;
  logic          go_on_q, go_on_d;

  always_comb begin
    brk_set    = 1'b0;
    brk_clr    = 1'b0;
    wch_set    = 1'b0;
    wch_clr    = 1'b0;
    status_d   = 1'b0;
    go_on_d    = 1'b0;
    brk_flag_d = brk_flag_q;
    brk_slot_d = brk_slot_q;
    wch_flag_d = wch_flag_q;
    wch_slot_d = wch_slot_q;
    wch_addr_d = wch_addr_q;
    cnt_d      = cnt_q;
    cnt_hit_d  = cnt_hit_q;
    halt_d     = halt_q;
    if (advance) begin
      case (kind_q)
        dbw_pkg::KindSetBreak: begin
          if (brk_full) status_d = 1'b1;
          else          brk_set  = 1'b1;
        end
        dbw_pkg::KindSetWatch: begin
          if (wch_full) status_d = 1'b1;
          else          wch_set  = 1'b1;
        end
        dbw_pkg::KindClrBreaks: begin
          brk_clr = 1'b1;
        end
        dbw_pkg::KindClrWatches: begin
          wch_clr = 1'b1;
        end
        dbw_pkg::KindRunStart: begin
          brk_flag_d = 1'b0;
          wch_flag_d = 1'b0;
          cnt_hit_d  = 1'b0;
          halt_d     = 1'b0;
          cnt_d      = '0;
        end
        dbw_pkg::KindContinue: begin
          cnt_d = '0;
        end
        dbw_pkg::KindInstr: begin
          halt_d = (opcode_q == dbw_pkg::HaltOpcode);
          // a pending watch stops at once, no match and no count
          if (!wch_flag_q) begin
            if (brk_match.hit) begin
              brk_flag_d = 1'b1;
              brk_slot_d = brk_match.slot;
            end
            cnt_hit_d = (cnt_q >= {1'b0, run_limit_q});
            if (cnt_q != '1) cnt_d = cnt_q + CW'(1);
            go_on_d = !(brk_flag_d || cnt_hit_d || bad_op_q || halt_d);
          end
        end
        dbw_pkg::KindAccess: begin
          if (wch_match.hit) begin
            wch_flag_d = 1'b1;
            wch_slot_d = wch_match.slot;
            wch_addr_d = addr_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_flag_q  <= 1'b0;
      brk_slot_q  <= '0;
      wch_flag_q  <= 1'b0;
      wch_slot_q  <= '0;
      wch_addr_q  <= '0;
      cnt_q       <= '0;
      cnt_hit_q   <= 1'b0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      brk_flag_q <= brk_flag_d;
      brk_slot_q <= brk_slot_d;
      wch_flag_q <= wch_flag_d;
      wch_slot_q <= wch_slot_d;
      wch_addr_q <= wch_addr_d;
      cnt_q      <= cnt_d;
      cnt_hit_q  <= cnt_hit_d;
      halt_q     <= halt_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      go_on_q  <= go_on_d;
    end
  end

  // alarm state only moves on advance, so it stays in step with the held result
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, halt_q, cnt_hit_q, wch_addr_q, wch_slot_q, wch_flag_q,
                          brk_slot_q, brk_flag_q, go_on_q, status_q};

endmodule

`default_nettype wire

>>> hw/rtl/dbw_checker.sv
// port-level checks for the debug break/watch unit, bound to the top level
`default_nettype none

module dbw_checker #(
  parameter int unsigned SLOTS = dbw_pkg::SlotsDefault
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [dbw_pkg::OutDataW-1:0]    m_axis_tdata
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // go_on only when no alarm is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |->
      !m_axis_tdata[2] && !m_axis_tdata[7] && !m_axis_tdata[28] && !m_axis_tdata[29])
    else $error("go_on with an alarm pending");

  // table full status comes only from set requests, never with go_on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("status and go_on together");

  // reported slots stay within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (32'(m_axis_tdata[6:3]) < SLOTS) && (32'(m_axis_tdata[11:8]) < SLOTS))
    else $error("slot index out of range");

  // a result becomes valid only after a request was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready) || $past(s_axis_tvalid, 2)
      || $past(s_axis_tvalid))
    else $error("result without a request");

endmodule

bind debug_break_watch_unit dbw_checker #(
  .SLOTS(SLOTS)
) u_dbw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

>>> bench/tb.sv
// self-checking bench for the debug break/watch unit: directed and random requests, scoreboard
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbw_pkg::*;

  localparam int Slots      = 10;
  localparam int CycleLimit = 300000;

  typedef struct packed {
    logic        status;
    logic        go_on;
    logic        brk_hit;
    logic [3:0]  brk_slot;
    logic        wch_hit;
    logic [3:0]  wch_slot;
    logic [15:0] wch_addr;
    logic        cnt_hit;
    logic        halt_hit;
  } trig_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [RunLimitW-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [KindW-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  // mirror of the trigger state
  logic [15:0]          bp_addr [Slots];
  logic                 bp_vld  [Slots];
  logic [15:0]          wr_lo   [Slots];
  logic [15:0]          wr_hi   [Slots];
  logic                 wr_vld  [Slots];
  logic                 bp_flag   = 1'b0;
  logic [3:0]           bp_idx    = '0;
  logic                 wr_flag   = 1'b0;
  logic [3:0]           wr_idx    = '0;
  logic [15:0]          wr_seen   = '0;
  logic [31:0]          icount    = '0;
  logic                 cnt_flag  = 1'b0;
  logic                 halt_flag = 1'b0;
  logic [RunLimitW-1:0] run_limit = RunLimitReset;

  trig_result_t pending_results[$];
  logic [15:0]  addr_pool [16];
  int           n_errors   = 0;
  int           n_sent     = 0;
  int           n_checked  = 0;
  int           cycles     = 0;
  bit           idle_en    = 1'b1;
  int           hold_serial_req  = 0;
  int           hold_serial_seen = 0;
  int           hold_left  = 0;
  int           stall_left = 0;

  debug_break_watch_unit #(
    .SLOTS(Slots)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic trig_result_t compute_triggers(dbw_kind_e kind, logic [15:0] addr,
                                                    logic [15:0] ahi, logic hg,
                                                    logic [7:0] opc, logic bad);
    trig_result_t r;
    int slot;
    r = '0;
    slot = -1;
    case (kind)
      KindSetBreak: begin
        for (int i = 0; i < Slots; i++) if (slot < 0 && !bp_vld[i]) slot = i;
        if (slot < 0) begin
          r.status = 1'b1;
        end else begin
          bp_addr[slot] = addr;
          bp_vld[slot]  = 1'b1;
        end
      end
      KindSetWatch: begin
        for (int i = 0; i < Slots; i++) if (slot < 0 && !wr_vld[i]) slot = i;
        if (slot < 0) begin
          r.status = 1'b1;
        end else begin
          wr_lo[slot]  = addr;
          wr_hi[slot]  = hg ? ahi : addr;
          wr_vld[slot] = 1'b1;
        end
      end
      KindClrBreaks: begin
        for (int i = 0; i < Slots; i++) bp_vld[i] = 1'b0;
      end
      KindClrWatches: begin
        for (int i = 0; i < Slots; i++) wr_vld[i] = 1'b0;
      end
      KindRunStart: begin
        wr_flag   = 1'b0;
        bp_flag   = 1'b0;
        cnt_flag  = 1'b0;
        halt_flag = 1'b0;
        icount    = '0;
      end
      KindContinue: begin
        icount = '0;
      end
      KindInstr: begin
        halt_flag = (opc == HaltOpcode);
        // a pending watch stops at once: no break match, no count
        if (!wr_flag) begin
          for (int i = 0; i < Slots; i++)
            if (slot < 0 && bp_vld[i] && bp_addr[i] == addr) slot = i;
          if (slot >= 0) begin
            bp_flag = 1'b1;
            bp_idx  = 4'(slot);
          end
          cnt_flag = (icount >= {1'b0, run_limit});
          if (icount != 32'hFFFF_FFFF) icount = icount + 1;
          r.go_on = !(bp_flag || wr_flag || cnt_flag || bad || halt_flag);
        end
      end
      default: begin
        for (int i = 0; i < Slots; i++)
          if (slot < 0 && wr_vld[i] && addr >= wr_lo[i] && addr <= wr_hi[i]) slot = i;
        if (slot >= 0) begin
          wr_flag = 1'b1;
          wr_idx  = 4'(slot);
          wr_seen = addr;
        end
      end
    endcase
    r.brk_hit  = bp_flag;
    r.brk_slot = bp_idx;
    r.wch_hit  = wr_flag;
    r.wch_slot = wr_idx;
    r.wch_addr = wr_seen;
    r.cnt_hit  = cnt_flag;
    r.halt_hit = halt_flag;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    trig_result_t exp_r;
    trig_result_t act_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_r.status   = m_axis_tdata[0];
      act_r.go_on    = m_axis_tdata[1];
      act_r.brk_hit  = m_axis_tdata[2];
      act_r.brk_slot = m_axis_tdata[6:3];
      act_r.wch_hit  = m_axis_tdata[7];
      act_r.wch_slot = m_axis_tdata[11:8];
      act_r.wch_addr = m_axis_tdata[27:12];
      act_r.cnt_hit  = m_axis_tdata[28];
      act_r.halt_hit = m_axis_tdata[29];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", exp_r.status, act_r.status);
        check_field("go_on", exp_r.go_on, act_r.go_on);
        check_field("break_hit", exp_r.brk_hit, act_r.brk_hit);
        check_field("break_slot", exp_r.brk_slot, act_r.brk_slot);
        check_field("watch_hit", exp_r.wch_hit, act_r.wch_hit);
        check_field("watch_slot", exp_r.wch_slot, act_r.wch_slot);
        check_field("hit_addr", exp_r.wch_addr, act_r.wch_addr);
        check_field("count_hit", exp_r.cnt_hit, act_r.cnt_hit);
        check_field("halt_hit", exp_r.halt_hit, act_r.halt_hit);
        n_checked++;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_serial_req != hold_serial_seen) begin
      hold_serial_seen = hold_serial_req;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= rst_ni;
      if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
    end
  end

  task automatic send_request(dbw_kind_e kind, logic [15:0] addr, logic [15:0] ahi,
                              logic hg, logic [7:0] opc, logic bad);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, bad, opc, hg, ahi, addr};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(compute_triggers(kind, addr, ahi, hg, opc, bad));
    n_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_run_limit(logic [RunLimitW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    run_limit   = value;
  endtask

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 9) < 6) return addr_pool[$urandom_range(0, 15)];
    return 16'($urandom);
  endfunction

  task automatic send_random_request();
    dbw_kind_e   kind;
    logic [15:0] addr;
    logic [15:0] ahi;
    logic [7:0]  opc;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      kind = KindInstr;
    else if (pick < 60) kind = KindAccess;
    else if (pick < 70) kind = KindSetBreak;
    else if (pick < 80) kind = KindSetWatch;
    else if (pick < 83) kind = KindClrBreaks;
    else if (pick < 86) kind = KindClrWatches;
    else if (pick < 92) kind = KindRunStart;
    else                kind = KindContinue;
    addr = pick_addr();
    // mostly small forward ranges, sometimes arbitrary (possibly empty) ones
    if ($urandom_range(0, 3) == 0) ahi = 16'($urandom);
    else ahi = addr + 16'($urandom_range(0, 64));
    opc = ($urandom_range(0, 7) == 0) ? HaltOpcode : 8'($urandom);
    send_request(kind, addr, ahi, 1'($urandom), opc, $urandom_range(0, 9) == 0);
  endtask

  task automatic test_directed();
    send_request(KindInstr, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindInstr, 16'h0001, 16'hFFFF, 1'b1, HaltOpcode, 1'b0);
    send_request(KindInstr, 16'h0002, 16'h0000, 1'b0, 8'hFF, 1'b1);
    send_request(KindRunStart, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1);
    send_request(KindSetBreak, 16'hFFFF, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindSetBreak, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindInstr, 16'h1234, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindInstr, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    // fill the breakpoint table, then one more set finds it full
    for (int i = 2; i < Slots; i++)
      send_request(KindSetBreak, 16'h2000 + 16'(i), 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindSetBreak, 16'h3000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindRunStart, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    // empty range, then a single-address watch
    send_request(KindSetWatch, 16'h9000, 16'h8000, 1'b1, 8'h00, 1'b0);
    send_request(KindSetWatch, 16'h4000, 16'hFFFF, 1'b0, 8'h00, 1'b0);
    send_request(KindAccess, 16'h8800, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindAccess, 16'h4001, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindAccess, 16'h4000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindInstr, 16'h0000, 16'h0000, 1'b0, HaltOpcode, 1'b0);
    send_request(KindClrBreaks, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindClrWatches, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindContinue, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    drain();
  endtask

  task automatic test_run_limit();
    write_run_limit(31'd1);
    send_request(KindRunStart, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    repeat (4) send_request(KindInstr, 16'($urandom), 16'h0000, 1'b0, 8'h00, 1'b0);
    send_request(KindContinue, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    repeat (2) send_request(KindInstr, 16'($urandom), 16'h0000, 1'b0, 8'h00, 1'b0);
    drain();
    write_run_limit(31'd3);
    send_request(KindRunStart, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    repeat (5) send_request(KindInstr, 16'($urandom), 16'h0000, 1'b0, 8'h00, 1'b0);
    drain();
    write_run_limit(31'h7FFF_FFFF);
    send_request(KindRunStart, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    repeat (3) send_request(KindInstr, 16'($urandom), 16'h0000, 1'b0, 8'h00, 1'b0);
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0, 1:    write_run_limit(31'($urandom_range(1, 40)));
          2, 3:    write_run_limit(31'($urandom_range(41, 2000)));
          default: write_run_limit(31'($urandom_range(1, 32'h7FFF_FFFF)));
        endcase
        idle_en = ($urandom_range(0, 3) != 0);
      end
      send_random_request();
    end
    drain();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_serial_req <= hold_serial_req + 1;
    repeat (30) send_random_request();
    drain();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (40) send_random_request();
    drain();
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) begin
      bp_vld[i] = 1'b0;
      wr_vld[i] = 1'b0;
    end
    for (int i = 0; i < 16; i++) addr_pool[i] = 16'($urandom);
    addr_pool[0] = 16'h0000;
    addr_pool[1] = 16'hFFFF;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_run_limit();
    test_random(400);
    test_backpressure();
    test_no_idle();
    $display("%0d requests sent, %0d results checked, %0d mismatches", n_sent, n_checked,
             n_errors);
    $display("covered: table fill/full/clear, break and watch matching, count limits, stalls");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
